FILE: design/gds_pkg.sv
// Shared constants for the 2x2 gray downscaler.
package gds_pkg;

	// Default maximum line width
	localparam int MAX_WIDTH_DEF = 4096;

	// Configuration register widths
	localparam int WIDTH_REG_W  = 13;
	localparam int HEIGHT_REG_W = 16;
	localparam int CFG_DATA_W   = 16;
	localparam int CFG_INDEX_W  = 1;

	// Register reset values
	localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = WIDTH_REG_W'(640);
	localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = HEIGHT_REG_W'(480);

	// Configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] CFG_SOURCE_WIDTH  = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] CFG_SOURCE_HEIGHT = 1'b1;

	// Pixel and pair-sum widths
	localparam int PIX_W = 8;
	localparam int SUM_W = 9;

endpackage

FILE: design/gray_downscale_2x2_average.sv
// 2x2 box-filter downscaler for a raster-order 8-bit gray stream.
//
// Takes one source pixel per clock while in_ready is high and gives one
// destination pixel for each 2x2 block, the rounded mean (a+b+c+d+2)>>2; an
// odd last column averages its vertical pair, an odd last row pairs with
// itself. Sustained rate is one pixel per clock with no bubbles between rows
// or frames while out_ready stays high. Even rows write horizontal pair sums
// into a single-port line buffer of (MAX_WIDTH+1)/2 entries and odd rows
// read them back, so the port serves at most one access per pixel. The line
// buffer needs no clearing after reset. Only write width and height through
// the configuration port while the stream is idle; nothing enforces it.
module gray_downscale_2x2_average
	import gds_pkg::*;
#(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// configuration
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	// source pixels
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [PIX_W-1:0]       pixel_in,
	// destination pixels
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [PIX_W-1:0]       pixel_out,
	output logic                   row_end,
	output logic                   frame_end
);

	localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
	localparam int CW  = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
	localparam int AW  = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
	localparam int WCW = (CW + 1 > WIDTH_REG_W) ? CW + 1 : WIDTH_REG_W;
	localparam int RCW = HEIGHT_REG_W + 1;

	typedef enum logic [1:0] {
		MODE_QUAD,
		MODE_VPAIR,
		MODE_HPAIR,
		MODE_PASS
	} mode_t;

	// Configuration registers
	logic [WIDTH_REG_W-1:0]  source_width_q;
	logic [HEIGHT_REG_W-1:0] source_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_width_q  <= WIDTH_RESET;
			source_height_q <= HEIGHT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SOURCE_WIDTH:  source_width_q  <= cfg_data[WIDTH_REG_W-1:0];
				CFG_SOURCE_HEIGHT: source_height_q <= cfg_data[HEIGHT_REG_W-1:0];
				default: ;
			endcase
		end
	end

	// Effective geometry: zero counts as one, width saturates at MAX_WIDTH
	logic [WCW-1:0] width_ext, eff_width;
	logic [RCW-1:0] eff_height;

	assign width_ext = WCW'(source_width_q);

	always_comb begin
		if (width_ext == '0)
			eff_width = WCW'(1);
		else if (width_ext > WCW'(MAX_WIDTH))
			eff_width = WCW'(MAX_WIDTH);
		else
			eff_width = width_ext;
		eff_height = (source_height_q == '0) ? RCW'(1) : RCW'(source_height_q);
	end

	// Position counters and held even-column pixel
	logic [CW-1:0]           col_q;
	logic [HEIGHT_REG_W-1:0] row_q;
	logic [PIX_W-1:0]        held_q;

	logic accept;
	logic last_col, last_row, odd_col, odd_row;
	logic [AW-1:0]    line_idx;
	logic [SUM_W-1:0] pair_sum;
	logic             emit;
	mode_t            mode;

	assign accept   = in_valid && in_ready;
	assign last_col = (WCW'(col_q) + WCW'(1)) >= eff_width;
	assign last_row = (RCW'(row_q) + RCW'(1)) >= eff_height;
	assign odd_col  = col_q[0];
	assign odd_row  = row_q[0];
	assign line_idx = AW'(col_q >> 1);
	assign pair_sum = odd_col ? (SUM_W'(held_q) + SUM_W'(pixel_in)) : SUM_W'(pixel_in);

	// Classify the pixel: which result, if any, it completes
	always_comb begin
		emit = 1'b0;
		mode = MODE_PASS;
		if (!odd_row) begin
			if (last_row && odd_col) begin
				emit = 1'b1;
				mode = MODE_HPAIR;
			end else if (last_row && last_col) begin
				emit = 1'b1;
				mode = MODE_PASS;
			end
		end else begin
			if (odd_col) begin
				emit = 1'b1;
				mode = MODE_QUAD;
			end else if (last_col) begin
				emit = 1'b1;
				mode = MODE_VPAIR;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			held_q <= '0;
		end else if (accept) begin
			if (!odd_col)
				held_q <= pixel_in;
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + HEIGHT_REG_W'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// Line buffer: even rows write pair sums, odd rows read them
	logic [SUM_W-1:0] line_mem [LINE_DEPTH];
	logic [SUM_W-1:0] above_s1;
	logic             mem_we, mem_re;

	assign mem_we = accept && !odd_row && (odd_col || last_col);
	assign mem_re = accept && odd_row;

	always_ff @(posedge clk) begin
		if (mem_we)
			line_mem[line_idx] <= pair_sum;
		if (mem_re)
			above_s1 <= line_mem[line_idx];
	end

	// Stage 1: waits for the line buffer read
	logic             s1_valid_q;
	logic             s1_adv;
	mode_t            mode_s1;
	logic [PIX_W-1:0] pix_s1, held_s1;
	logic             row_end_s1, frame_end_s1;

	assign s1_adv   = s1_valid_q && (!out_valid || out_ready);
	assign in_ready = !s1_valid_q || s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s1_valid_q <= 1'b0;
		else if (in_ready)
			s1_valid_q <= accept && emit;
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			mode_s1      <= mode;
			pix_s1       <= pixel_in;
			held_s1      <= held_q;
			row_end_s1   <= last_col;
			frame_end_s1 <= last_col && last_row;
		end
	end

	// Rounded averages
	logic [9:0]       avg_sum;
	logic [PIX_W-1:0] avg_value;

	always_comb begin
		case (mode_s1)
			MODE_QUAD: begin
				avg_sum   = 10'(above_s1) + 10'(held_s1) + 10'(pix_s1) + 10'd2;
				avg_value = avg_sum[9:2];
			end
			MODE_VPAIR: begin
				avg_sum   = 10'(above_s1) + 10'(pix_s1) + 10'd1;
				avg_value = avg_sum[8:1];
			end
			MODE_HPAIR: begin
				avg_sum   = 10'(held_s1) + 10'(pix_s1) + 10'd1;
				avg_value = avg_sum[8:1];
			end
			default: begin
				avg_sum   = 10'(pix_s1);
				avg_value = pix_s1;
			end
		endcase
	end

	// Output register
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (s1_adv)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	logic [PIX_W-1:0] pixel_out_q;
	logic             row_end_q, frame_end_q;

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			pixel_out_q <= avg_value;
			row_end_q   <= row_end_s1;
			frame_end_q <= frame_end_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign pixel_out = pixel_out_q;
	assign row_end   = row_end_q;
	assign frame_end = frame_end_q;

	// Checks
	a_frame_end_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_end |-> row_end)
		else $error("frame_end without row_end");

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && out_valid && !out_ready |-> !in_ready)
		else $error("request accepted while stage 1 is stalled");

	a_quad_reaches_s1: assert property (@(posedge clk) disable iff (!arst_n)
		accept && odd_row && odd_col |=> s1_valid_q)
		else $error("block completion lost before stage 1");

	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re))
		else $error("line buffer read and write in one cycle");

endmodule
